/* rtl/tlbat_pkg.sv */
// Shared types and constants for the TLB address translator.
// Used by tlbat_ctrl, tlbat_datapath and tlb_address_translate_top.
package tlbat_pkg;

    localparam int TLB_ENTRIES_DEF = 16;

    localparam int VADDR_W  = 32;
    localparam int PAGE_W   = 18;
    localparam int OFFS_W   = 12;
    localparam int SEG_W    = 2;
    localparam int ACCESS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int ATTR_W   = 5;
    localparam int PADDR_W  = 30;
    localparam int FAULT_W  = 3;
    localparam int EIU_W    = 5;

    // input word: vaddr, user_mode, access, entry_index, entry_segment,
    // entry_virtual_page, entry_physical_page, entry_attributes
    localparam int S_FIELDS_W = VADDR_W + 1 + ACCESS_W + SLOT_W + SEG_W
                              + PAGE_W + PAGE_W + ATTR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = PADDR_W + FAULT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [EIU_W-1:0] EIU_RESET = EIU_W'(16);

    // attribute bit positions
    localparam int ATTR_VALID = 0;
    localparam int ATTR_READ  = 1;
    localparam int ATTR_EXEC  = 3;
    localparam int ATTR_DIRTY = 4;

    localparam logic [ACCESS_W-1:0] ACCESS_WRITE_ONLY = 3'b010;

    typedef enum logic {
        MODE_TRANSLATE = 1'b0,
        MODE_WRITE     = 1'b1
    } t_mode;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_OK    = 3'd0,
        FAULT_PRIV  = 3'd1,
        FAULT_MISS  = 3'd2,
        FAULT_MULTI = 3'd3,
        FAULT_PROT  = 3'd4
    } t_fault;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_MATCH   = 2'd1,
        S_RESOLVE = 2'd2
    } t_state;

    typedef struct packed {
        logic capture;  // latch the accepted input word
        logic compare;  // register the match vector
        logic finish;   // resolve, update the store, load the output register
    } t_dp_cmd;

endpackage

/* rtl/tlb_address_translate_top.sv */
// Top level of the fully associative TLB address translator.
// Depends on tlbat_pkg, tlbat_ctrl and tlbat_datapath.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+--------------------------------
//  s (item)  | in  | i_s_tvalid / o_s_tready      | i_s_tdata (88b), i_s_tuser (mode)
//  m (result)| out | o_m_tvalid / i_m_tready      | o_m_tdata (40b)
//  cfg       | in  | i_cfg_valid / o_cfg_ready    | i_cfg_data = entries_in_use
//
//  One word in flight: capture, compare and resolve run in turn, and a
//  new word is accepted only once the resolve stage, which updates the
//  entry store, has finished.
//  The result register lets the next word enter while a result waits;
//  a stalled result holds the resolve stage until it is taken.
//  Reset (synchronous, active low) invalidates all entries at once and
//  sets entries_in_use to 16. Config is always ready.
module tlb_address_translate_top #(
    parameter int TLB_ENTRIES = tlbat_pkg::TLB_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [31:0] vaddr, [32] user_mode, [35:33] access, [39:36] entry_index,
    // [41:40] entry_segment, [59:42] entry_virtual_page,
    // [77:60] entry_physical_page, [82:78] entry_attributes, [87:83] zero
    input  logic [tlbat_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [0] mode
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [29:0] physical_address, [32:30] fault_code, [39:33] zero
    output logic [tlbat_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tlbat_pkg::EIU_W-1:0]      i_cfg_data
);

    tlbat_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    tlbat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    tlbat_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

/* rtl/tlbat_ctrl.sv */
// Sequencer for the TLB address translator: capture, compare, resolve.
// Depends on tlbat_pkg; drives the datapath through t_dp_cmd.
module tlbat_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output tlbat_pkg::t_dp_cmd o_cmd
);

    tlbat_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlbat_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlbat_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = tlbat_pkg::S_MATCH;
            end
            tlbat_pkg::S_MATCH: begin
                n_state = tlbat_pkg::S_RESOLVE;
            end
            tlbat_pkg::S_RESOLVE: begin
                if (!r_out_valid || i_m_tready) n_state = tlbat_pkg::S_IDLE;
            end
            default: begin
                n_state = tlbat_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            tlbat_pkg::S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            tlbat_pkg::S_MATCH: begin
                o_cmd.compare = 1'b1;
            end
            tlbat_pkg::S_RESOLVE: begin
                // hold the result back while the previous word still waits
                o_cmd.finish = !r_out_valid || i_m_tready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    a_accept_to_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == tlbat_pkg::S_MATCH))
        else $error("accepted word did not move to compare");

    a_match_to_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlbat_pkg::S_MATCH) |=> (r_state == tlbat_pkg::S_RESOLVE))
        else $error("compare stage did not advance");

    a_finish_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (o_m_tvalid && r_state == tlbat_pkg::S_IDLE))
        else $error("resolved word not presented");

endmodule

/* rtl/tlbat_datapath.sv */
// Datapath of the TLB address translator: entry store, parallel tag
// compare, fault resolution and output register. Depends on tlbat_pkg.
module tlbat_datapath #(
    parameter int TLB_ENTRIES = tlbat_pkg::TLB_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tlbat_pkg::t_dp_cmd                 i_cmd,
    input  logic                               i_s_tuser,
    input  logic [tlbat_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic                               i_cfg_we,
    input  logic [tlbat_pkg::EIU_W-1:0]        i_cfg_data,
    output logic [tlbat_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    // captured input word
    tlbat_pkg::t_mode                   r_mode;
    logic [tlbat_pkg::VADDR_W-1:0]      r_vaddr;
    logic                               r_user;
    logic [tlbat_pkg::ACCESS_W-1:0]     r_access;
    logic [tlbat_pkg::SLOT_W-1:0]       r_entry_index;
    logic [tlbat_pkg::SEG_W-1:0]        r_entry_seg;
    logic [tlbat_pkg::PAGE_W-1:0]       r_entry_vpage;
    logic [tlbat_pkg::PAGE_W-1:0]       r_entry_ppage;
    logic [tlbat_pkg::ATTR_W-1:0]       r_entry_attr;

    logic [tlbat_pkg::EIU_W-1:0]        r_eiu;

    // entry store; each entry is compared in place
    logic [tlbat_pkg::SEG_W-1:0]        r_seg   [TLB_ENTRIES];
    logic [tlbat_pkg::PAGE_W-1:0]       r_vpage [TLB_ENTRIES];
    logic [tlbat_pkg::PAGE_W-1:0]       r_ppage [TLB_ENTRIES];
    logic [tlbat_pkg::ATTR_W-1:0]       r_attr  [TLB_ENTRIES];

    logic [TLB_ENTRIES-1:0]             r_match;

    logic [tlbat_pkg::PADDR_W-1:0]      r_pa, n_pa;
    tlbat_pkg::t_fault                  r_fault, n_fault;

    logic [tlbat_pkg::PAGE_W-1:0]       sel_ppage;
    logic                               perm_ok;
    logic                               hit_any;
    logic                               hit_multi;
    logic [tlbat_pkg::SEG_W-1:0]        seg;
    logic                               set_dirty;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode        <= tlbat_pkg::t_mode'(i_s_tuser);
            r_vaddr       <= i_s_tdata[31:0];
            r_user        <= i_s_tdata[32];
            r_access      <= i_s_tdata[35:33];
            r_entry_index <= i_s_tdata[39:36];
            r_entry_seg   <= i_s_tdata[41:40];
            r_entry_vpage <= i_s_tdata[59:42];
            r_entry_ppage <= i_s_tdata[77:60];
            r_entry_attr  <= i_s_tdata[82:78];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eiu <= tlbat_pkg::EIU_RESET;
        end else if (i_cfg_we) begin
            r_eiu <= i_cfg_data;
        end
    end

    // entries at or past the search count are masked off
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_match[i] <= r_attr[i][tlbat_pkg::ATTR_VALID]
                           && (r_vpage[i] == r_vaddr[29:12])
                           && (r_seg[i] == r_vaddr[31:30])
                           && (i < int'(r_eiu));
            end
        end
    end

    always_comb begin
        sel_ppage = '0;
        perm_ok   = 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (r_match[i]) begin
                sel_ppage = sel_ppage | r_ppage[i];
                perm_ok   = perm_ok
                          | ((r_attr[i][tlbat_pkg::ATTR_EXEC:tlbat_pkg::ATTR_READ] & r_access)
                             == r_access);
            end
        end
        hit_any   = |r_match;
        hit_multi = !$onehot0(r_match);
        seg       = r_vaddr[31:30];
    end

    always_comb begin
        n_pa      = '0;
        n_fault   = tlbat_pkg::FAULT_OK;
        set_dirty = 1'b0;
        priority if (r_mode == tlbat_pkg::MODE_WRITE) begin
            n_fault = tlbat_pkg::FAULT_OK;
        end else if (r_user && seg != 2'd0) begin
            n_fault = tlbat_pkg::FAULT_PRIV;
        end else if (seg[1]) begin
            // unmapped supervisor segments
            n_pa = r_vaddr[29:0];
        end else if (!hit_any) begin
            n_fault = tlbat_pkg::FAULT_MISS;
        end else if (hit_multi) begin
            n_fault = tlbat_pkg::FAULT_MULTI;
        end else if (!perm_ok) begin
            n_fault = tlbat_pkg::FAULT_PROT;
        end else begin
            n_pa      = {sel_ppage, r_vaddr[11:0]};
            set_dirty = (r_access == tlbat_pkg::ACCESS_WRITE_ONLY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_pa    <= n_pa;
            r_fault <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_attr[i] <= '0;
            end
        end else if (i_cmd.finish) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                if (r_mode == tlbat_pkg::MODE_WRITE && int'(r_entry_index) == i) begin
                    r_attr[i] <= r_entry_attr;
                end else if (set_dirty && r_match[i]) begin
                    r_attr[i][tlbat_pkg::ATTR_DIRTY] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_mode == tlbat_pkg::MODE_WRITE) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                if (int'(r_entry_index) == i) begin
                    r_seg[i]   <= r_entry_seg;
                    r_vpage[i] <= r_entry_vpage;
                    r_ppage[i] <= r_entry_ppage;
                end
            end
        end
    end

    assign o_m_tdata = {{(tlbat_pkg::M_TDATA_W - tlbat_pkg::M_FIELDS_W){1'b0}}, r_fault, r_pa};

    a_write_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_mode == tlbat_pkg::MODE_WRITE)
        |=> (r_pa == '0 && r_fault == tlbat_pkg::FAULT_OK))
        else $error("entry write produced a nonzero result");

    a_dirty_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && set_dirty) |-> ($onehot(r_match) && !seg[1]))
        else $error("dirty update without a single mapped hit");

    a_fault_zero_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && n_fault != tlbat_pkg::FAULT_OK) |=> (r_pa == '0))
        else $error("faulting word produced a nonzero address");

endmodule
